[sv/assert_macros.svh]
// Assertion helpers; clocked on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge
`define ASSERT_IMPL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// cond must never be true
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[sv/ppmd_pkg.sv]
package ppmd_pkg;

  localparam int COORD_BITS = 12;
  localparam int DIFF_W     = COORD_BITS + 1;
  // sum of three squared differences
  localparam int SQ_W       = 2 * COORD_BITS + 2;
  // multiplier operand: signed, holds a dot product or an unsigned square sum
  localparam int OP_W       = SQ_W + 1;
  localparam int PROD_W     = 2 * OP_W;
  localparam int NUM_W      = 2 * SQ_W;
  localparam int DIST_W     = 26;
  localparam int MAX_W      = (SQ_W > DIST_W) ? SQ_W : DIST_W;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam int TDATA_IN_W  = ((6 * COORD_BITS + 7) / 8) * 8;
  localparam int TDATA_OUT_W = ((DIST_W + 7) / 8) * 8;
  localparam int APB_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_TOL = '0;

  // step counter covers the multiply sequence and the divider iterations
  localparam int STEP_COUNT = 15;
  localparam int CNT_MAX    = (SQ_W > STEP_COUNT) ? SQ_W : STEP_COUNT;
  localparam int CNT_W      = $clog2(CNT_MAX);

  // multiply schedule: three products per square sum / dot product
  localparam logic [CNT_W-1:0] STEP_VV  = CNT_W'(0);
  localparam logic [CNT_W-1:0] STEP_WW  = CNT_W'(3);
  localparam logic [CNT_W-1:0] STEP_DOT = CNT_W'(6);
  localparam logic [CNT_W-1:0] STEP_UU  = CNT_W'(9);
  localparam logic [CNT_W-1:0] STEP_P1  = CNT_W'(12);
  localparam logic [CNT_W-1:0] STEP_P2  = CNT_W'(13);
  localparam logic [CNT_W-1:0] STEP_END = CNT_W'(14);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SQ_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } ppmd_state_e;

  function automatic logic signed [DIFF_W-1:0] coord_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  function automatic logic [DIST_W-1:0] sat_dist(input logic [SQ_W-1:0] d);
    logic [MAX_W-1:0] dw;
    dw = MAX_W'(d);
    if (dw > MAX_W'(DIST_MAX)) begin
      return DIST_MAX;
    end
    return dw[DIST_W-1:0];
  endfunction

endpackage

[sv/point_polyline_min_distance_sq_core.sv]
// Minimum squared distance from a query point to a 3D polyline streamed one
// vertex per item. Each vertex after the first closes a segment; its squared
// distance (clamped to the nearer endpoint, floored in the interior case) is
// folded into a running minimum, which freezes once it is below
// freeze_tolerance_sq. A result is sent on the item marked tlast. All
// products run through one shared 27x27 multiplier and the quotient through
// a radix-2 restoring divider. An item that closes a segment runs the 15
// multiply steps, and the 26 divide steps as well only when the projection
// falls inside the segment; a single-vertex polyline runs only the multiply
// steps. A first vertex that is not last stores its point and restarts the
// minimum; a frozen vertex skips the arithmetic. The input is not ready
// again until an item is through. A finished result waits in the output
// register while the next item is accepted; an item that ends a polyline
// holds off the input until the previous result has been taken.
`include "assert_macros.svh"

module point_polyline_min_distance_sq_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // query_x, query_y, query_z, vertex_x, vertex_y, vertex_z
  input  logic [ppmd_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
  // first_vertex
  input  logic [0:0]                           s_axis_tuser,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // min_distance_sq
  output logic [ppmd_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
  // too_short
  output logic [0:0]                           m_axis_tuser,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ppmd_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [ppmd_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [ppmd_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import ppmd_pkg::*;

  ppmd_state_e state_q, state_d;

  logic signed [COORD_BITS-1:0] in_qx, in_qy, in_qz, in_vx, in_vy, in_vz;
  logic                         in_first, in_last, accept;

  logic [CNT_W-1:0]             cnt_q, pj;
  logic [1:0]                   comp;
  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q, prev_z_q;
  logic signed [DIFF_W-1:0]     vx_q, vy_q, vz_q, wx_q, wy_q, wz_q, ux_q, uy_q, uz_q;
  logic signed [DIFF_W-1:0]     v_c, w_c, u_c;
  logic [SQ_W-1:0]              vv_q, ww_q, uu_q, d_q;
  logic signed [OP_W-1:0]       dot_q;
  logic signed [OP_W-1:0]       op_a, op_b;
  logic signed [PROD_W-1:0]     prod_c, prod_q;
  logic [NUM_W-1:0]             num_q, num_fin;
  logic [SQ_W-1:0]              rem_q, nlo_q, rem_n, nlo_n;
  logic [SQ_W:0]                trial;
  logic                         div_ge;
  logic                         vv_zero, dot_nonpos, dot_ge_vv, need_div;

  logic                         short_q, last_q, calc_q, frozen_q;
  logic [DIST_W-1:0]            min_q, tol_q, dsat, min_n;
  logic                         out_valid_q, out_short_q, out_free, out_load;
  logic [DIST_W-1:0]            out_dist_q;

  assign in_qx    = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
  assign in_qy    = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
  assign in_qz    = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
  assign in_vx    = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
  assign in_vy    = s_axis_tdata[4*COORD_BITS +: COORD_BITS];
  assign in_vz    = s_axis_tdata[5*COORD_BITS +: COORD_BITS];
  assign in_first = s_axis_tuser[0];
  assign in_last  = s_axis_tlast;
  assign accept   = s_axis_tvalid && s_axis_tready;

  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = (state_q == ST_DONE) && (state_d == ST_IDLE) && last_q;

  // segment classification, valid once the square sums are complete
  assign vv_zero    = (vv_q == '0);
  assign dot_nonpos = (dot_q <= 0);
  assign dot_ge_vv  = (dot_q >= $signed({1'b0, vv_q}));
  assign need_div   = !short_q && !vv_zero && !dot_nonpos && !dot_ge_vv;

  // ---------------- shared multiplier ----------------
  always_comb begin
    comp = '0;
    if (cnt_q < STEP_WW) begin
      comp = 2'(cnt_q - STEP_VV);
    end else if (cnt_q < STEP_DOT) begin
      comp = 2'(cnt_q - STEP_WW);
    end else if (cnt_q < STEP_UU) begin
      comp = 2'(cnt_q - STEP_DOT);
    end else if (cnt_q < STEP_P1) begin
      comp = 2'(cnt_q - STEP_UU);
    end
    v_c = (comp == 2'd0) ? vx_q : (comp == 2'd1) ? vy_q : vz_q;
    w_c = (comp == 2'd0) ? wx_q : (comp == 2'd1) ? wy_q : wz_q;
    u_c = (comp == 2'd0) ? ux_q : (comp == 2'd1) ? uy_q : uz_q;
    if (cnt_q < STEP_WW) begin
      op_a = OP_W'(v_c);
      op_b = OP_W'(v_c);
    end else if (cnt_q < STEP_DOT) begin
      op_a = OP_W'(w_c);
      op_b = OP_W'(w_c);
    end else if (cnt_q < STEP_UU) begin
      op_a = OP_W'(v_c);
      op_b = OP_W'(w_c);
    end else if (cnt_q < STEP_P1) begin
      op_a = OP_W'(u_c);
      op_b = OP_W'(u_c);
    end else if (cnt_q == STEP_P1) begin
      op_a = $signed({1'b0, ww_q});
      op_b = $signed({1'b0, vv_q});
    end else begin
      op_a = dot_q;
      op_b = dot_q;
    end
  end

  assign prod_c  = op_a * op_b;
  assign pj      = cnt_q - CNT_W'(1);
  assign num_fin = num_q - prod_q[NUM_W-1:0];

  // ---------------- restoring divider step ----------------
  always_comb begin
    trial  = {rem_q, nlo_q[SQ_W-1]};
    div_ge = (trial >= {1'b0, vv_q});
    if (div_ge) begin
      rem_n = SQ_W'(trial - {1'b0, vv_q});
    end else begin
      rem_n = trial[SQ_W-1:0];
    end
    nlo_n = {nlo_q[SQ_W-2:0], div_ge};
  end

  assign dsat  = sat_dist(d_q);
  assign min_n = (calc_q && !short_q && (dsat < min_q)) ? dsat : min_q;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_first && !in_last) begin
            state_d = ST_IDLE;
          end else if (in_first || !frozen_q) begin
            state_d = ST_MUL;
          end else if (in_last) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MUL: begin
        if (cnt_q == STEP_END) begin
          state_d = need_div ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (cnt_q == DIV_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!last_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- outputs ----------------
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = TDATA_OUT_W'(out_dist_q);
    m_axis_tuser  = out_short_q;
    pready        = 1'b1;
    prdata        = (paddr == REG_TOL) ? APB_DATA_W'(tol_q) : '0;
  end

  // ---------------- control state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_z_q    <= '0;
      min_q       <= DIST_MAX;
      frozen_q    <= 1'b0;
      tol_q       <= DIST_W'(1);
      short_q     <= 1'b0;
      last_q      <= 1'b0;
      calc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (psel && penable && pwrite && pready && (paddr == REG_TOL)) begin
        tol_q <= pwdata[DIST_W-1:0];
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cnt_q    <= '0;
            prev_x_q <= in_vx;
            prev_y_q <= in_vy;
            prev_z_q <= in_vz;
            short_q  <= in_first && in_last;
            last_q   <= in_last;
            calc_q   <= in_first || !frozen_q;
            if (in_first) begin
              min_q    <= DIST_MAX;
              frozen_q <= 1'b0;
            end
          end
        end
        ST_MUL, ST_DIV: begin
          cnt_q <= (state_d == state_q) ? cnt_q + CNT_W'(1) : '0;
        end
        ST_DONE: begin
          if (state_d == ST_IDLE) begin
            if (last_q) begin
              min_q       <= DIST_MAX;
              frozen_q    <= 1'b0;
            end else begin
              min_q    <= min_n;
              frozen_q <= (min_n < tol_q);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          vx_q <= coord_diff(in_vx, prev_x_q);
          vy_q <= coord_diff(in_vy, prev_y_q);
          vz_q <= coord_diff(in_vz, prev_z_q);
          wx_q <= coord_diff(in_qx, prev_x_q);
          wy_q <= coord_diff(in_qy, prev_y_q);
          wz_q <= coord_diff(in_qz, prev_z_q);
          ux_q <= coord_diff(in_qx, in_vx);
          uy_q <= coord_diff(in_qy, in_vy);
          uz_q <= coord_diff(in_qz, in_vz);
        end
      end
      ST_MUL: begin
        prod_q <= prod_c;
        // product of the previous step is registered in prod_q and accumulated in the next cycle
        if (cnt_q != STEP_VV) begin
          if (pj == STEP_VV) begin
            vv_q <= prod_q[SQ_W-1:0];
          end else if (pj < STEP_WW) begin
            vv_q <= vv_q + prod_q[SQ_W-1:0];
          end else if (pj == STEP_WW) begin
            ww_q <= prod_q[SQ_W-1:0];
          end else if (pj < STEP_DOT) begin
            ww_q <= ww_q + prod_q[SQ_W-1:0];
          end else if (pj == STEP_DOT) begin
            dot_q <= prod_q[OP_W-1:0];
          end else if (pj < STEP_UU) begin
            dot_q <= dot_q + prod_q[OP_W-1:0];
          end else if (pj == STEP_UU) begin
            uu_q <= prod_q[SQ_W-1:0];
          end else if (pj < STEP_P1) begin
            uu_q <= uu_q + prod_q[SQ_W-1:0];
          end else if (pj == STEP_P1) begin
            num_q <= prod_q[NUM_W-1:0];
          end
        end
        if (cnt_q == STEP_END) begin
          // quotient fits SQ_W bits, so the upper half already sits below vv
          rem_q <= num_fin[NUM_W-1:SQ_W];
          nlo_q <= num_fin[SQ_W-1:0];
          if (short_q) begin
            d_q <= uu_q;
          end else if (vv_zero || dot_nonpos) begin
            d_q <= ww_q;
          end else if (dot_ge_vv) begin
            d_q <= uu_q;
          end
        end
      end
      ST_DIV: begin
        rem_q <= rem_n;
        nlo_q <= nlo_n;
        if (cnt_q == DIV_LAST) begin
          d_q <= nlo_n;
        end
      end
      ST_DONE: begin
        if ((state_d == ST_IDLE) && last_q) begin
          out_dist_q  <= short_q ? dsat : min_n;
          out_short_q <= short_q;
        end
      end
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_rem_below_vv, (state_q == ST_DIV) |-> (rem_q < vv_q), "divider remainder not below divisor")
  `ASSERT_NEVER(a_div_by_zero, (state_q == ST_DIV) && (vv_q == '0), "divide with zero-length segment")
  `ASSERT_IMPL(a_quo_bound, ((state_q == ST_DONE) && ($past(state_q) == ST_DIV)) |-> (d_q <= ww_q), "interior distance exceeds start distance")
  `ASSERT_IMPL(a_out_from_done, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE), "result raised outside completion")

endmodule

[sim/point_polyline_min_distance_sq_core_test.sv]
`timescale 1ns / 100ps

module point_polyline_min_distance_sq_core_test;
  import ppmd_pkg::*;

  localparam int MAX_WAIT      = 16;
  // settle time leaves room for a vertex still in flight
  localparam int SETTLE_CYCLES = 80;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [DIST_W-1:0] TOL_TOP = DIST_W'(50307075);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t qx, qy, qz;
    coord_t vx, vy, vz;
    logic   first_v;
    logic   last_v;
  } vertex_item_t;

  typedef struct {
    logic [DIST_W-1:0] dist_sq;
    logic              too_short;
  } dist_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // query_x, query_y, query_z, vertex_x, vertex_y, vertex_z
  logic [TDATA_IN_W-1:0]  s_axis_tdata;
  // first_vertex
  logic [0:0]             s_axis_tuser;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // min_distance_sq
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  // too_short
  logic [0:0]             m_axis_tuser;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CFG_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  point_polyline_min_distance_sq_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  vertex_item_t vertex_queue[$];
  dist_result_t dist_queue[$];
  int           errors;
  longint       cycle_count;
  int           send_gap;
  int           stall_left;
  bit           send_burst;
  bit           recv_burst;

  // shadow of the block state
  logic [DIST_W-1:0] tol_sq;
  coord_t            prev_x, prev_y, prev_z;
  logic [DIST_W-1:0] run_min;
  bit                frozen;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int draw_wait(bit burst);
    return burst ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  function automatic longint point_dist_sq(longint ax, longint ay, longint az,
                                           longint bx, longint by, longint bz);
    return (ax - bx) * (ax - bx) + (ay - by) * (ay - by) + (az - bz) * (az - bz);
  endfunction

  function automatic logic [DIST_W-1:0] clip_dist(longint d);
    if (d > longint'(DIST_MAX)) begin
      return DIST_MAX;
    end
    return DIST_W'(d);
  endfunction

  // squared distance from the query point to the segment prev -> vertex
  function automatic longint segment_dist_sq(vertex_item_t it);
    longint vx, vy, vz, wx, wy, wz, ww, vv, dot;
    vx  = longint'(it.vx) - longint'(prev_x);
    vy  = longint'(it.vy) - longint'(prev_y);
    vz  = longint'(it.vz) - longint'(prev_z);
    wx  = longint'(it.qx) - longint'(prev_x);
    wy  = longint'(it.qy) - longint'(prev_y);
    wz  = longint'(it.qz) - longint'(prev_z);
    ww  = wx * wx + wy * wy + wz * wz;
    vv  = vx * vx + vy * vy + vz * vz;
    dot = vx * wx + vy * wy + vz * wz;
    if (vv == 0 || dot <= 0) begin
      return ww;
    end
    if (dot >= vv) begin
      return point_dist_sq(longint'(it.qx), longint'(it.qy), longint'(it.qz),
                           longint'(it.vx), longint'(it.vy), longint'(it.vz));
    end
    return (ww * vv - dot * dot) / vv;
  endfunction

  function automatic void fold_vertex(vertex_item_t it);
    dist_result_t      r;
    logic [DIST_W-1:0] d;
    if (it.first_v) begin
      run_min = DIST_MAX;
      frozen  = 1'b0;
      if (it.last_v) begin
        r.dist_sq   = clip_dist(point_dist_sq(longint'(it.qx), longint'(it.qy),
                                              longint'(it.qz), longint'(it.vx),
                                              longint'(it.vy), longint'(it.vz)));
        r.too_short = 1'b1;
        dist_queue.insert(dist_queue.size(), r);
        prev_x = it.vx;
        prev_y = it.vy;
        prev_z = it.vz;
        return;
      end
    end else if (!frozen) begin
      d = clip_dist(segment_dist_sq(it));
      if (d < run_min) begin
        run_min = d;
      end
      if (run_min < tol_sq) begin
        frozen = 1'b1;
      end
    end
    prev_x = it.vx;
    prev_y = it.vy;
    prev_z = it.vz;
    if (it.last_v) begin
      r.dist_sq   = run_min;
      r.too_short = 1'b0;
      dist_queue.insert(dist_queue.size(), r);
      run_min = DIST_MAX;
      frozen  = 1'b0;
    end
  endfunction

  // item driver
  always @(negedge clk_i) begin : drive_items
    vertex_item_t nxt;
    if (rst_ni && !s_axis_tvalid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (vertex_queue.size() > 0) begin
        nxt = vertex_queue[0];
        s_axis_tdata  <= TDATA_IN_W'({nxt.vz, nxt.vy, nxt.vx, nxt.qz, nxt.qy, nxt.qx});
        s_axis_tuser  <= nxt.first_v;
        s_axis_tlast  <= nxt.last_v;
        s_axis_tvalid <= 1'b1;
      end
    end
    if (rst_ni) begin
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // accept monitor and result checker
  always @(posedge clk_i) begin : watch_ports
    dist_result_t exp_r;
    vertex_item_t taken;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (dist_queue.size() == 0) begin
        $display("%0t: result with none expected: dist %0d too_short %0b", $time,
                 m_axis_tdata[DIST_W-1:0], m_axis_tuser[0]);
        errors++;
      end else begin
        exp_r = dist_queue.pop_front();
        if (m_axis_tdata[DIST_W-1:0] !== exp_r.dist_sq) begin
          $display("%0t: min_distance_sq expected %0d actual %0d", $time, exp_r.dist_sq,
                   m_axis_tdata[DIST_W-1:0]);
          errors++;
        end
        if (m_axis_tuser[0] !== exp_r.too_short) begin
          $display("%0t: too_short expected %0b actual %0b", $time, exp_r.too_short,
                   m_axis_tuser[0]);
          errors++;
        end
      end
      stall_left <= draw_wait(recv_burst);
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      taken = vertex_queue.pop_front();
      fold_vertex(taken);
      s_axis_tvalid <= 1'b0;
      send_gap      <= draw_wait(send_burst);
    end
  end

  // idling mode changes now and then; run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count[5:0] == 6'd0) begin
      send_burst <= ($urandom_range(0, 3) == 0);
      recv_burst <= ($urandom_range(0, 3) == 0);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("point_polyline_min_distance_sq_core_test failed");
      $finish;
    end
  end

  function automatic void push_vertex(int qx, int qy, int qz, int vx, int vy, int vz,
                                      bit first_v, bit last_v);
    vertex_item_t it;
    it.qx = coord_t'(qx);
    it.qy = coord_t'(qy);
    it.qz = coord_t'(qz);
    it.vx = coord_t'(vx);
    it.vy = coord_t'(vy);
    it.vz = coord_t'(vz);
    it.first_v = first_v;
    it.last_v  = last_v;
    vertex_queue.insert(vertex_queue.size(), it);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0:       return coord_t'(-2048);
      1:       return coord_t'(2047);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t near_coord(coord_t c, int spread);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 2047) begin
      v = 2047;
    end
    if (v < -2048) begin
      v = -2048;
    end
    return coord_t'(v);
  endfunction

  task automatic wait_idle();
    while (vertex_queue.size() != 0 || s_axis_tvalid || dist_queue.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [DIST_W-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_TOL;
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tol_sq = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== APB_DATA_W'(value)) begin
      $display("%0t: freeze_tolerance_sq read expected %0d actual %0d", $time, value, rd);
      errors++;
    end
  endtask

  task automatic load_directed();
    // no first mark after reset: segment starts at the origin
    push_vertex(0, 5, 0, 10, 0, 0, 0, 0);
    push_vertex(0, 5, 0, 20, 0, 0, 0, 1);
    // single vertex, farthest and coincident
    push_vertex(-2048, -2048, -2048, 2047, 2047, 2047, 1, 1);
    push_vertex(2047, -2048, 0, 2047, -2048, 0, 1, 1);
    // corner to corner segments
    push_vertex(2047, -2048, 2047, -2048, -2048, -2048, 1, 0);
    push_vertex(2047, -2048, 2047, 2047, 2047, 2047, 0, 0);
    push_vertex(-2048, 2047, -2048, 2047, -2048, -2048, 0, 1);
    // zero-length segment
    push_vertex(100, -3, 7, 5, 5, 5, 1, 0);
    push_vertex(100, -3, 7, 5, 5, 5, 0, 1);
    // projection before the start
    push_vertex(-50, 3, 0, 0, 0, 0, 1, 0);
    push_vertex(-50, 3, 0, 100, 0, 0, 0, 1);
    // projection past the end
    push_vertex(150, 3, 0, 0, 0, 0, 1, 0);
    push_vertex(150, 3, 0, 100, 0, 0, 0, 1);
    // projection exactly on the end point
    push_vertex(100, 9, 0, 0, 0, 0, 1, 0);
    push_vertex(100, 9, 0, 100, 0, 0, 0, 1);
    // hit at zero freezes, later segments are ignored
    push_vertex(0, 0, 0, -10, 0, 0, 1, 0);
    push_vertex(0, 0, 0, 10, 0, 0, 0, 0);
    push_vertex(300, 300, 300, 10, 500, 0, 0, 0);
    push_vertex(300, 300, 300, 700, 500, 0, 0, 1);
    // query point moves within a polyline
    push_vertex(0, 0, 0, 0, 0, 0, 1, 0);
    push_vertex(50, 7, 0, 100, 0, 0, 0, 1);
    // restart before the end, then a last vertex with no first mark
    push_vertex(9, 9, 9, 1, 1, 1, 1, 0);
    push_vertex(3, 3, 3, -1, -1, -1, 1, 0);
    push_vertex(3, 3, 3, -1, -1, 100, 0, 1);
    push_vertex(1, 2, 3, 0, 0, 0, 0, 1);
  endtask

  task automatic load_random(int n_items);
    int           sent;
    int           len;
    int           spread;
    bit           near;
    vertex_item_t it;
    coord_t       qx, qy, qz;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        // stray vertex with arbitrary marks
        push_vertex(int'(rand_coord()), int'(rand_coord()), int'(rand_coord()),
                    int'(rand_coord()), int'(rand_coord()), int'(rand_coord()),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len    = ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 16))
                                             : int'($urandom_range(1, 6));
        near   = $urandom_range(0, 2) != 0;
        case ($urandom_range(0, 2))
          0:       spread = 4;
          1:       spread = 64;
          default: spread = 600;
        endcase
        qx = rand_coord();
        qy = rand_coord();
        qz = rand_coord();
        for (int i = 0; i < len; i++) begin
          if (i > 0 && $urandom_range(0, 15) == 0) begin
            qx = near_coord(qx, spread);
            qy = near_coord(qy, spread);
            qz = near_coord(qz, spread);
          end
          if (i == 0 || $urandom_range(0, 9) != 0) begin
            it.vx = near ? near_coord(qx, spread) : rand_coord();
            it.vy = near ? near_coord(qy, spread) : rand_coord();
            it.vz = near ? near_coord(qz, spread) : rand_coord();
          end
          // otherwise repeat the vertex: zero-length segment
          it.qx = qx;
          it.qy = qy;
          it.qz = qz;
          it.first_v = (i == 0) && ($urandom_range(0, 19) != 0);
          it.last_v  = (i == len - 1);
          vertex_queue.insert(vertex_queue.size(), it);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = REG_TOL;
    pwdata        = '0;
    errors        = 0;
    cycle_count   = 0;
    send_gap      = 0;
    stall_left    = 0;
    send_burst    = 1'b0;
    recv_burst    = 1'b0;
    tol_sq        = DIST_W'(1);
    prev_x        = '0;
    prev_y        = '0;
    prev_z        = '0;
    run_min       = DIST_MAX;
    frozen        = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    load_directed();
    wait_idle();
    write_tolerance('0);
    load_random(200);
    wait_idle();
    write_tolerance(TOL_TOP);
    load_random(150);
    wait_idle();
    write_tolerance(DIST_W'($urandom_range(2, 5000)));
    load_random(200);
    wait_idle();
    write_tolerance(DIST_W'($urandom_range(5000, 50307075)));
    load_random(100);
    wait_idle();
    write_tolerance(DIST_W'(1));
    load_random(250);
    wait_idle();

    if (errors == 0) begin
      $display("point_polyline_min_distance_sq_core_test passed");
    end else begin
      $display("point_polyline_min_distance_sq_core_test failed");
    end
    $finish;
  end

endmodule
